/* hdl/fps_pkg.sv */
// Shared types, character codes and helper functions of the format printer.
package fps_pkg;

    localparam int ARG_WIDTH_DEFAULT = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int COUNT_WIDTH       = 32;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_S_LOWER = 8'h73;
    localparam logic [7:0] CH_D_LOWER = 8'h64;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_N_LOWER = 8'h6E;
    localparam logic [7:0] CH_U_LOWER = 8'h75;
    localparam logic [7:0] CH_L_LOWER = 8'h6C;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    localparam logic [2:0] NULL_LAST_IDX = 3'd5;

    typedef enum logic [1:0] {
        OP_FMT_CHAR = 2'd0,
        OP_NUM_ARG  = 2'd1,
        OP_STR_CHAR = 2'd2,
        OP_END      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_STR  = 2'd1,
        KIND_DEC  = 2'd2,
        KIND_HEX  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_DEC  = 2'd1,
        CMD_HEX  = 2'd2,
        CMD_END  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic       with_null;
        logic       with_total;
    } cmd_ctl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONVERT,
        BK_SIGN,
        BK_DIGITS,
        BK_NULL,
        BK_TOTAL
    } back_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = CH_ZERO + {4'h0, d};
        end
        else
        begin
            r = CH_A_LOWER + {4'h0, d} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = CH_LPAREN;
            3'd1:    r = CH_N_LOWER;
            3'd2:    r = CH_U_LOWER;
            3'd3:    r = CH_L_LOWER;
            3'd4:    r = CH_L_LOWER;
            default: r = CH_RPAREN;
        endcase
        return r;
    endfunction

endpackage

/* hdl/fps_queue.sv */
// Small register FIFO that carries commands from the front end to the back end.
module fps_queue #(
    parameter int WIDTH = 44,
    parameter int DEPTH = fps_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import fps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/fps_front.sv */
// Front end: accepts input beats, tracks the format parser state and issues commands.
module fps_front #(
    parameter int ARG_WIDTH = fps_pkg::ARG_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [7:0]            character,
    input  logic [31:0]           number,
    input  logic                  string_is_null,
    input  logic                  format_done,
    input  logic                  q_full,
    output logic                  push,
    output fps_pkg::cmd_ctl_t     push_ctl,
    output logic [ARG_WIDTH-1:0]  push_value
);
    import fps_pkg::*;

    logic  percent_reg, percent_next;
    kind_t pending_reg, pending_next;
    logic  accept;
    op_t   op;
    logic [ARG_WIDTH+31:0] num_wide;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign op         = op_t'(operation);
    // Only the low ARG_WIDTH bits of the argument count; wider settings zero-extend.
    assign num_wide   = {{ARG_WIDTH{1'b0}}, number};
    assign push_value = num_wide[ARG_WIDTH-1:0];

    always_comb
    begin
        percent_next        = percent_reg;
        pending_next        = pending_reg;
        push                = 1'b0;
        push_ctl.kind       = CMD_CHAR;
        push_ctl.ch         = character;
        push_ctl.with_null  = 1'b0;
        push_ctl.with_total = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_FMT_CHAR:
                begin
                    pending_next = KIND_NONE;
                    if (percent_reg)
                    begin
                        percent_next = 1'b0;
                        priority if (character == CH_S_LOWER)
                            pending_next = KIND_STR;
                        else if (character == CH_D_LOWER)
                            pending_next = KIND_DEC;
                        else if (character == CH_X_LOWER)
                            pending_next = KIND_HEX;
                        else
                            pending_next = KIND_NONE;
                    end
                    else if (character == CH_PERCENT)
                    begin
                        percent_next = 1'b1;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                OP_NUM_ARG:
                begin
                    if (pending_reg == KIND_DEC)
                    begin
                        push          = 1'b1;
                        push_ctl.kind = CMD_DEC;
                        pending_next  = KIND_NONE;
                    end
                    else if (pending_reg == KIND_HEX)
                    begin
                        push          = 1'b1;
                        push_ctl.kind = CMD_HEX;
                        pending_next  = KIND_NONE;
                    end
                end
                OP_STR_CHAR:
                begin
                    push = (pending_reg == KIND_STR);
                end
                OP_END:
                begin
                    push_ctl.kind       = CMD_END;
                    push_ctl.with_null  = (pending_reg == KIND_STR) && string_is_null;
                    push_ctl.with_total = format_done;
                    push = push_ctl.with_null || format_done;
                    if (pending_reg == KIND_STR)
                    begin
                        pending_next = KIND_NONE;
                    end
                    if (format_done)
                    begin
                        percent_next = 1'b0;
                        pending_next = KIND_NONE;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percent_reg <= 1'b0;
            pending_reg <= KIND_NONE;
        end
        else
        begin
            percent_reg <= percent_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* hdl/fps_back.sv */
// Back end: executes commands, converts numbers digit by digit and drives the result beats.
module fps_back #(
    parameter int ARG_WIDTH = fps_pkg::ARG_WIDTH_DEFAULT,
    parameter int QW        = ARG_WIDTH + 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  logic [QW-1:0]                    pop_data,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_char,
    output logic                             is_total,
    output logic [fps_pkg::COUNT_WIDTH-1:0]  total_count,
    output logic                             last_of_run
);
    import fps_pkg::*;

    localparam int DEC_DIGITS = (ARG_WIDTH * 1233) / 4096 + 1;
    localparam int DIG_BITS   = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(ARG_WIDTH + 1);

    back_state_t state_reg, state_next;
    cmd_ctl_t    ctl;
    logic [ARG_WIDTH-1:0] cmd_value, mag;
    logic [DIG_BITS+ARG_WIDTH-1:0] pad_value, dabble;

    logic [DEC_DIGITS-1:0][3:0] digs_reg, digs_next, adj;
    logic [ARG_WIDTH-1:0]       bin_reg, bin_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [2:0]                 idx_reg, idx_next;
    logic                       started_reg, started_next;
    logic                       neg_reg, neg_next;
    logic                       tot_reg, tot_next;
    logic [COUNT_WIDTH-1:0]     count_reg, count_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       is_total_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic       last_reg;

    logic       adv, cnt_last, skip;
    logic       emit, emit_total, emit_last;
    logic [7:0] emit_char;

    assign ctl       = cmd_ctl_t'(pop_data[QW-1:ARG_WIDTH]);
    assign cmd_value = pop_data[ARG_WIDTH-1:0];
    assign mag       = cmd_value[ARG_WIDTH-1] ? (~cmd_value + 1'b1) : cmd_value;
    assign pad_value = {{DIG_BITS{1'b0}}, cmd_value};

    assign adv      = !out_valid_reg || !out_stall;
    assign cnt_last = (cnt_reg == CNT_W'(1));
    assign skip     = (digs_reg[DEC_DIGITS-1] == 4'h0) && !started_reg && !cnt_last;

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            adj[i] = (digs_reg[i] >= 4'd5) ? digs_reg[i] + 4'd3 : digs_reg[i];
        end
        dabble = {adj, bin_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (ctl.kind)
                        CMD_CHAR: state_next = BK_IDLE;
                        CMD_DEC:  state_next = BK_CONVERT;
                        CMD_HEX:  state_next = BK_DIGITS;
                        CMD_END:  state_next = ctl.with_null ? BK_NULL : BK_TOTAL;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_CONVERT:
            begin
                if (cnt_last)
                begin
                    state_next = neg_reg ? BK_SIGN : BK_DIGITS;
                end
            end
            BK_SIGN:
            begin
                if (adv)
                begin
                    state_next = BK_DIGITS;
                end
            end
            BK_DIGITS:
            begin
                if (!skip && adv && cnt_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_NULL:
            begin
                if (adv && idx_reg == NULL_LAST_IDX)
                begin
                    state_next = tot_reg ? BK_TOTAL : BK_IDLE;
                end
            end
            BK_TOTAL:
            begin
                if (adv)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        emit         = 1'b0;
        emit_total   = 1'b0;
        emit_last    = 1'b0;
        emit_char    = 8'h00;
        digs_next    = digs_reg;
        bin_next     = bin_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        tot_next     = tot_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (ctl.kind)
                        CMD_CHAR:
                        begin
                            if (adv)
                            begin
                                pop       = 1'b1;
                                emit      = 1'b1;
                                emit_char = ctl.ch;
                                emit_last = 1'b1;
                            end
                        end
                        CMD_DEC:
                        begin
                            pop          = 1'b1;
                            neg_next     = cmd_value[ARG_WIDTH-1];
                            bin_next     = mag;
                            digs_next    = '0;
                            cnt_next     = CNT_W'(ARG_WIDTH);
                            started_next = 1'b0;
                        end
                        CMD_HEX:
                        begin
                            pop          = 1'b1;
                            neg_next     = 1'b0;
                            digs_next    = pad_value[DIG_BITS-1:0];
                            cnt_next     = CNT_W'(DEC_DIGITS);
                            started_next = 1'b0;
                        end
                        CMD_END:
                        begin
                            pop      = 1'b1;
                            idx_next = '0;
                            tot_next = ctl.with_total;
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            BK_CONVERT:
            begin
                {digs_next, bin_next} = {dabble[DIG_BITS+ARG_WIDTH-2:0], 1'b0};
                cnt_next = cnt_last ? CNT_W'(DEC_DIGITS) : cnt_reg - 1'b1;
            end
            BK_SIGN:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    emit_char = CH_MINUS;
                end
            end
            BK_DIGITS:
            begin
                if (skip)
                begin
                    digs_next = {digs_reg[DEC_DIGITS-2:0], 4'h0};
                    cnt_next  = cnt_reg - 1'b1;
                end
                else if (adv)
                begin
                    emit         = 1'b1;
                    emit_char    = hex_char(digs_reg[DEC_DIGITS-1]);
                    emit_last    = cnt_last;
                    started_next = 1'b1;
                    digs_next    = {digs_reg[DEC_DIGITS-2:0], 4'h0};
                    cnt_next     = cnt_reg - 1'b1;
                end
            end
            BK_NULL:
            begin
                if (adv)
                begin
                    emit      = 1'b1;
                    emit_char = null_char(idx_reg);
                    emit_last = (idx_reg == NULL_LAST_IDX) && !tot_reg;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            BK_TOTAL:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    emit_total = 1'b1;
                    emit_last  = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (emit_total)
        begin
            count_next = '0;
        end
        else if (emit && count_reg != {COUNT_WIDTH{1'b1}})
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            tot_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            started_reg   <= started_next;
            neg_reg       <= neg_next;
            tot_reg       <= tot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digs_reg <= digs_next;
        bin_reg  <= bin_next;
        if (emit)
        begin
            out_char_reg <= emit_total ? 8'h00 : emit_char;
            is_total_reg <= emit_total;
            total_reg    <= emit_total ? count_reg : '0;
            last_reg     <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign is_total    = is_total_reg;
    assign total_count = total_reg;
    assign last_of_run = last_reg;

endmodule

/* hdl/format_print_string_decimal_hex.sv */
// Top level of the printf-style format printer for %s, %d and %x.
//
// This block expands a printf-style format stream, one input beat per format
// character, argument or string character, into a stream of output character
// beats. Ordinary format characters are echoed; '%' followed by s, d or x waits
// for its argument. A numeric argument (the low ARG_WIDTH bits of number) is
// printed as signed decimal with a leading '-' and no leading zeros, or as
// lowercase hexadecimal. String characters are echoed while a %s is pending,
// and a string end flagged as null prints "(null)". A format end beat returns
// the saturating character count in a result with is_total set and clears the
// block. Every input beat that causes output marks its final output beat with
// last_of_run; beats that cause no output produce nothing. The front end
// accepts one input beat per cycle while its four-entry command queue has room,
// so input keeps flowing while the back end works on an earlier argument. The
// back end emits one character per cycle when the output is not stalled. An
// echoed character is emitted directly at dispatch. A decimal argument passes
// through dispatch, the shift-and-add-3 binary to BCD converter, the minus
// sign if negative and then a scan of the decimal digit positions (10 for
// ARG_WIDTH 32), with leading zeros skipped without output. A hexadecimal
// argument skips the converter and goes from dispatch to the same digit scan.
// A null string goes through dispatch and the six characters of "(null)",
// followed by the count when the format ends.
module format_print_string_decimal_hex #(
    parameter int ARG_WIDTH = fps_pkg::ARG_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       operation,
    input  logic [7:0]                       character,
    input  logic [31:0]                      number,
    input  logic                             string_is_null,
    input  logic                             format_done,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_char,
    output logic                             is_total,
    output logic [fps_pkg::COUNT_WIDTH-1:0]  total_count,
    output logic                             last_of_run
);
    import fps_pkg::*;

    // A queue entry holds the command control word and the argument value.
    localparam int QW = $bits(cmd_ctl_t) + ARG_WIDTH;

    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;
    cmd_ctl_t             push_ctl;
    logic [ARG_WIDTH-1:0] push_value;
    logic [QW-1:0]        push_data;
    logic [QW-1:0]        pop_data;

    assign push_data = {push_ctl, push_value};

    // The front end decodes the format stream and only issues a command for
    // beats that produce output.
    fps_front #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .character      (character),
        .number         (number),
        .string_is_null (string_is_null),
        .format_done    (format_done),
        .q_full         (q_full),
        .push           (push),
        .push_ctl       (push_ctl),
        .push_value     (push_value)
    );

    fps_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // The back end owns the character count, since only it knows when each
    // character actually leaves the block.
    fps_back #(
        .ARG_WIDTH (ARG_WIDTH),
        .QW        (QW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .is_total    (is_total),
        .total_count (total_count),
        .last_of_run (last_of_run)
    );

endmodule
